// ===== src/bsc_pkg.sv =====
// ----------------------------------------------------------------------------
// bsc_pkg
// Types, constants and helpers shared by the barometric compensation core.
// ----------------------------------------------------------------------------
`default_nettype none

package bsc_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_AC123 = 3'd0;
  localparam logic [2:0] CFG_AC456 = 3'd1;
  localparam logic [2:0] CFG_B12   = 3'd2;
  localparam logic [2:0] CFG_MCMD  = 3'd3;
  localparam logic [2:0] CFG_OSS   = 3'd4;
  localparam logic [2:0] CFG_TOFF  = 3'd5;

  localparam int CFG_DATA_W = 48;
  localparam logic [15:0] TOFF_RESET = 16'd520;

  // datasheet constants
  localparam logic [31:0] B6_BASE    = 32'd4000;
  localparam logic [31:0] B4_BIAS    = 32'd32768;
  localparam logic [31:0] B7_SCALE   = 32'd50000;
  localparam logic [31:0] P_COEF_SQ  = 32'd3038;
  localparam logic [31:0] P_COEF_LIN = 32'd7357;
  localparam logic [31:0] P_BIAS     = 32'd3791;
  localparam logic [31:0] S32_MIN    = 32'h8000_0000;
  localparam logic [31:0] S32_MAX    = 32'h7FFF_FFFF;
  localparam logic [17:0] P_MAX      = 18'h3FFFF;

  // divider geometry
  localparam int DIV_W      = 32;
  localparam int DIV_SIDE_W = 64;

  // one incoming beat
  typedef struct packed {
    logic [15:0] raw_temperature;
    logic [23:0] raw_pressure_bytes;
  } sample_t;

  // one outgoing beat
  typedef struct packed {
    logic signed [15:0] temperature_tenths;
    logic [17:0]        pressure_pa;
    logic               fault;
  } result_t;

  // divider request and response
  typedef struct packed {
    logic                  valid;
    logic [DIV_W-1:0]      num;
    logic [DIV_W-1:0]      den;
    logic [DIV_SIDE_W-1:0] side;
  } div_req_t;

  typedef struct packed {
    logic                  valid;
    logic [DIV_W-1:0]      quot;
    logic [DIV_SIDE_W-1:0] side;
  } div_rsp_t;

  // data riding along the temperature division
  typedef struct packed {
    logic [31:0] x1;
    logic [18:0] up;
    logic        qneg;
    logic        dzero;
  } tside_t;

  // data riding along the pressure division
  typedef struct packed {
    logic [15:0] t;
    logic        fault;
    logic        big;
    logic        dzero;
  } pside_t;

  localparam int TSIDE_W = $bits(tside_t);
  localparam int PSIDE_W = $bits(pside_t);

  // arithmetic right shift of a 32-bit word read as signed
  function automatic logic [31:0] asr32(input logic [31:0] v, input int unsigned s);
    logic signed [31:0] sv;
    sv = $signed(v);
    return 32'(sv >>> s);
  endfunction

endpackage

`default_nettype wire

// ===== src/bsc_div_pipe.sv =====
// ----------------------------------------------------------------------------
// bsc_div_pipe
// Unsigned restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_div_pipe import bsc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     en,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic [DIV_W-1:0]      rem  [DIV_W];
  logic [DIV_W-1:0]      num  [DIV_W];
  logic [DIV_W-1:0]      den  [DIV_W];
  logic [DIV_W-1:0]      quo  [DIV_W];
  logic [DIV_SIDE_W-1:0] side [DIV_W];
  logic                  vld  [DIV_W];

  for (genvar k = 0; k < DIV_W; k++) begin : g_stage
    logic [DIV_W-1:0]      rem_in, num_in, den_in, quo_in;
    logic [DIV_SIDE_W-1:0] side_in;
    logic                  vld_in;
    logic [DIV_W+1:0]      trial;
    logic [DIV_W-1:0]      rem_next;
    logic                  qbit;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign num_in  = req.num;
      assign den_in  = req.den;
      assign quo_in  = '0;
      assign side_in = req.side;
      assign vld_in  = req.valid;
    end else begin : g_rest
      assign rem_in  = rem[k-1];
      assign num_in  = num[k-1];
      assign den_in  = den[k-1];
      assign quo_in  = quo[k-1];
      assign side_in = side[k-1];
      assign vld_in  = vld[k-1];
    end

    // shift in next numerator bit and try subtracting the divisor
    always_comb begin
      trial = {1'b0, rem_in, num_in[DIV_W-1]} - {2'b00, den_in};
      qbit  = ~trial[DIV_W+1];
      if (qbit) begin
        rem_next = trial[DIV_W-1:0];
      end else begin
        rem_next = {rem_in[DIV_W-2:0], num_in[DIV_W-1]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld_in;
      end
      if (en) begin
        rem[k]  <= rem_next;
        num[k]  <= {num_in[DIV_W-2:0], 1'b0};
        den[k]  <= den_in;
        quo[k]  <= {quo_in[DIV_W-2:0], qbit};
        side[k] <= side_in;
      end
    end
  end

  assign rsp.valid = vld[DIV_W-1];
  assign rsp.quot  = quo[DIV_W-1];
  assign rsp.side  = side[DIV_W-1];

endmodule

`default_nettype wire

// ===== src/barometric_sensor_compensation_core.sv =====
// Throughput: one beat per cycle while no result is stalled; the two
// 32-stage bit-per-stage dividers (temperature and pressure) set the depth,
// not the rate.
// A stalled result freezes the whole pipeline in place.
// Reset (synchronous, active high) empties the pipeline and restores the
// calibration registers to zero and the temperature offset to 520.
// ----------------------------------------------------------------------------
// barometric_sensor_compensation_core
// Pipelined integer temperature and pressure compensation.
// ----------------------------------------------------------------------------
`default_nettype none

module barometric_sensor_compensation_core import bsc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  sample_valid,
  output logic                       sample_stall,
  input  wire sample_t               sample,
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output result_t                    result,
  input  wire logic                  cfg_we,
  input  wire logic [2:0]            cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration registers
  logic [47:0] ac123, ac456;
  logic [31:0] b12, mcmd;
  logic [1:0]  oss;
  logic [15:0] toff;

  always_ff @(posedge clk) begin
    if (rst) begin
      ac123 <= '0;
      ac456 <= '0;
      b12   <= '0;
      mcmd  <= '0;
      oss   <= '0;
      toff  <= TOFF_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_AC123: ac123 <= cfg_data[47:0];
        CFG_AC456: ac456 <= cfg_data[47:0];
        CFG_B12:   b12   <= cfg_data[31:0];
        CFG_MCMD:  mcmd  <= cfg_data[31:0];
        CFG_OSS:   oss   <= cfg_data[1:0];
        CFG_TOFF:  toff  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // calibration words, sign extended where signed
  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, toff32;
  assign ac1    = {{16{ac123[47]}}, ac123[47:32]};
  assign ac2    = {{16{ac123[31]}}, ac123[31:16]};
  assign ac3    = {{16{ac123[15]}}, ac123[15:0]};
  assign ac4    = {16'b0, ac456[47:32]};
  assign ac5    = {16'b0, ac456[31:16]};
  assign ac6    = {16'b0, ac456[15:0]};
  assign b1     = {{16{b12[31]}}, b12[31:16]};
  assign b2     = {{16{b12[15]}}, b12[15:0]};
  assign mc     = {{16{mcmd[31]}}, mcmd[31:16]};
  assign md     = {{16{mcmd[15]}}, mcmd[15:0]};
  assign toff32 = {{16{toff[15]}}, toff};

  // whole pipeline advances unless the output beat is held
  logic en;
  assign en           = ~(result_valid & result_stall);
  assign sample_stall = ~en;

  logic a_v, b_v, c_v, d_v, e_v, f_v, g_v, h_v, i_v, j_v, k_v, l_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0; b_v <= 1'b0; c_v <= 1'b0;
      d_v <= 1'b0; e_v <= 1'b0; f_v <= 1'b0; g_v <= 1'b0;
      h_v <= 1'b0; i_v <= 1'b0; j_v <= 1'b0;
      k_v <= 1'b0; l_v <= 1'b0;
    end else if (en) begin
      a_v <= sample_valid;
      b_v <= a_v;
      c_v <= b_v;
      d_v <= trsp.valid;
      e_v <= d_v;
      f_v <= e_v;
      g_v <= f_v;
      h_v <= g_v;
      i_v <= h_v;
      j_v <= i_v;
      k_v <= prsp.valid;
      l_v <= k_v;
    end
  end

  // stage a: raw words, pressure alignment
  logic [31:0] a_diff;
  logic [18:0] a_up;
  logic [23:0] up_shift;
  assign up_shift = sample.raw_pressure_bytes >> (4'd8 - {2'b00, oss});

  always_ff @(posedge clk) begin
    if (en) begin
      a_diff <= {16'b0, sample.raw_temperature} - ac6;
      a_up   <= up_shift[18:0];
    end
  end

  // stage b: (ut - ac6) * ac5
  logic [31:0] b_prod;
  logic [18:0] b_up;
  always_ff @(posedge clk) begin
    if (en) begin
      b_prod <= a_diff * ac5;
      b_up   <= a_up;
    end
  end

  // stage c: x1 and temperature divisor
  logic [31:0] c_x1, c_d;
  logic [18:0] c_up;
  logic [31:0] x1_t;
  assign x1_t = asr32(b_prod, 15);

  always_ff @(posedge clk) begin
    if (en) begin
      c_x1 <= x1_t;
      c_d  <= x1_t + md;
      c_up <= b_up;
    end
  end

  // temperature division: |mc * 2048| / |x1 + md|
  logic [31:0] mc_num, mc_mag, d_mag;
  tside_t   tside_in, tside_out;
  div_req_t treq;
  div_rsp_t trsp;

  always_comb begin
    mc_num         = mc << 11;
    mc_mag         = mc_num[31] ? (32'd0 - mc_num) : mc_num;
    d_mag          = c_d[31] ? (32'd0 - c_d) : c_d;
    tside_in.x1    = c_x1;
    tside_in.up    = c_up;
    tside_in.qneg  = mc[31] ^ c_d[31];
    tside_in.dzero = (c_d == 32'd0);
    treq.valid     = c_v;
    treq.num       = mc_mag;
    treq.den       = d_mag;
    treq.side      = DIV_SIDE_W'(tside_in);
  end

  bsc_div_pipe u_tdiv (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .req (treq),
    .rsp (trsp)
  );

  // stage d: b5, temperature result, b6
  logic [31:0] x2_t, b5, tt;
  logic [15:0] t_sat;
  logic        t_fault;
  logic [31:0] d_b6;
  logic [15:0] d_t;
  logic        d_fault;
  logic [18:0] d_up;

  always_comb begin
    tside_out = tside_t'(trsp.side[TSIDE_W-1:0]);
    if (tside_out.dzero) begin
      if (mc == 32'd0) begin
        x2_t = 32'd0;
      end else if (mc[31]) begin
        x2_t = S32_MIN;
      end else begin
        x2_t = S32_MAX;
      end
    end else if (tside_out.qneg) begin
      x2_t = 32'd0 - trsp.quot;
    end else begin
      x2_t = trsp.quot;
    end
    b5 = tside_out.x1 + x2_t - toff32;
    tt = asr32(b5 + 32'd8, 4);
    t_fault = tside_out.dzero;
    if ($signed(tt) > 32'sd32767) begin
      t_sat   = 16'h7FFF;
      t_fault = 1'b1;
    end else if ($signed(tt) < -32'sd32768) begin
      t_sat   = 16'h8000;
      t_fault = 1'b1;
    end else begin
      t_sat = tt[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_b6    <= b5 - B6_BASE;
      d_t     <= t_sat;
      d_fault <= t_fault;
      d_up    <= tside_out.up;
    end
  end

  // stage e: products of b6
  logic [31:0] e_b6sq, e_ac2b6, e_ac3b6;
  logic [15:0] e_t;
  logic        e_fault;
  logic [18:0] e_up;
  always_ff @(posedge clk) begin
    if (en) begin
      e_b6sq  <= d_b6 * d_b6;
      e_ac2b6 <= ac2 * d_b6;
      e_ac3b6 <= ac3 * d_b6;
      e_t     <= d_t;
      e_fault <= d_fault;
      e_up    <= d_up;
    end
  end

  // stage f: scaled terms
  logic [31:0] f_sq, f_x2, f_x1q;
  logic [15:0] f_t;
  logic        f_fault;
  logic [18:0] f_up;
  always_ff @(posedge clk) begin
    if (en) begin
      f_sq    <= asr32(e_b6sq, 12);
      f_x2    <= asr32(e_ac2b6, 11);
      f_x1q   <= asr32(e_ac3b6, 13);
      f_t     <= e_t;
      f_fault <= e_fault;
      f_up    <= e_up;
    end
  end

  // stage g: b2 * sq and b1 * sq
  logic [31:0] g_b2sq, g_b1sq, g_x2, g_x1q;
  logic [15:0] g_t;
  logic        g_fault;
  logic [18:0] g_up;
  always_ff @(posedge clk) begin
    if (en) begin
      g_b2sq  <= b2 * f_sq;
      g_b1sq  <= b1 * f_sq;
      g_x2    <= f_x2;
      g_x1q   <= f_x1q;
      g_t     <= f_t;
      g_fault <= f_fault;
      g_up    <= f_up;
    end
  end

  // stage h: b3 and x3 for b4
  logic [31:0] x3_b3, b3_pre, x3_b4;
  logic [31:0] h_b3, h_x3;
  logic [15:0] h_t;
  logic        h_fault;
  logic [18:0] h_up;

  always_comb begin
    x3_b3  = asr32(g_b2sq, 11) + g_x2;
    b3_pre = ((ac1 << 2) + x3_b3) << oss;
    x3_b4  = asr32(g_x1q + asr32(g_b1sq, 16) + 32'd2, 2);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_b3    <= asr32(b3_pre + 32'd2, 2);
      h_x3    <= x3_b4;
      h_t     <= g_t;
      h_fault <= g_fault;
      h_up    <= g_up;
    end
  end

  // stage i: b4 and up - b3
  logic [31:0] b4_prod;
  logic [31:0] i_b4, i_diff;
  logic [15:0] i_t;
  logic        i_fault;
  assign b4_prod = ac4 * (h_x3 + B4_BIAS);

  always_ff @(posedge clk) begin
    if (en) begin
      i_b4    <= b4_prod >> 15;
      i_diff  <= {13'b0, h_up} - h_b3;
      i_t     <= h_t;
      i_fault <= h_fault;
    end
  end

  // stage j: b7
  logic [31:0] j_b7, j_b4;
  logic [15:0] j_t;
  logic        j_fault;
  always_ff @(posedge clk) begin
    if (en) begin
      j_b7    <= i_diff * (B7_SCALE >> oss);
      j_b4    <= i_b4;
      j_t     <= i_t;
      j_fault <= i_fault;
    end
  end

  // pressure division: b7 * 2 / b4, or b7 / b4 then doubled when b7 is large
  pside_t   pside_in, pside_out;
  div_req_t preq;
  div_rsp_t prsp;

  always_comb begin
    pside_in.t     = j_t;
    pside_in.fault = j_fault;
    pside_in.big   = j_b7[31];
    pside_in.dzero = (j_b4 == 32'd0);
    preq.valid     = j_v;
    preq.num       = j_b7[31] ? j_b7 : {j_b7[30:0], 1'b0};
    preq.den       = j_b4;
    preq.side      = DIV_SIDE_W'(pside_in);
  end

  bsc_div_pipe u_pdiv (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .req (preq),
    .rsp (prsp)
  );

  // stage k: p, (p >> 8)^2 and -7357 * p
  logic [31:0] p_k, xa_k;
  logic [31:0] k_p, k_xsq, k_m;
  pside_t      k_side;

  always_comb begin
    pside_out = pside_t'(prsp.side[PSIDE_W-1:0]);
    p_k       = pside_out.big ? {prsp.quot[30:0], 1'b0} : prsp.quot;
    xa_k      = asr32(p_k, 8);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k_p    <= p_k;
      k_xsq  <= xa_k * xa_k;
      k_m    <= 32'd0 - (P_COEF_LIN * p_k);
      k_side <= pside_out;
    end
  end

  // stage l: 3038 term
  logic [31:0] l_xm, l_x2, l_p;
  pside_t      l_side;
  always_ff @(posedge clk) begin
    if (en) begin
      l_xm   <= k_xsq * P_COEF_SQ;
      l_x2   <= asr32(k_m, 16);
      l_p    <= k_p;
      l_side <= k_side;
    end
  end

  // output stage: final pressure, clamp, result register
  logic [31:0] pr;
  logic [17:0] p_sat;
  logic        p_fault;

  always_comb begin
    pr      = l_p + asr32(asr32(l_xm, 16) + l_x2 + P_BIAS, 4);
    p_fault = l_side.fault;
    if (l_side.dzero) begin
      p_sat   = P_MAX;
      p_fault = 1'b1;
    end else if (pr[31]) begin
      p_sat   = '0;
      p_fault = 1'b1;
    end else if (pr > {14'b0, P_MAX}) begin
      p_sat   = P_MAX;
      p_fault = 1'b1;
    end else begin
      p_sat = pr[17:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= l_v;
    end
    if (en) begin
      result.temperature_tenths <= $signed(l_side.t);
      result.pressure_pa        <= p_sat;
      result.fault              <= p_fault;
    end
  end

  // checks
  a_rst_empty : assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result beat present right after reset");

  a_stall_cause : assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> (result_valid && result_stall))
    else $error("input stalled without a held result beat");

  a_hold_valid : assert property (@(posedge clk) disable iff (rst)
    (!en && k_v) |=> (k_v && result_valid))
    else $error("pipeline stage lost its beat during a stall");

endmodule

`default_nettype wire

// ===== tb/barometric_sensor_compensation_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// barometric_sensor_compensation_core_tb
// Drives raw temperature and pressure beats through the core under several
// calibration sets. After-reset results are checked against fixed values, all
// others against a local integer model of the datasheet formulas. Both sides
// idle at random; the receiver holds off long enough to back the pipeline up.
// ----------------------------------------------------------------------------
module barometric_sensor_compensation_core_tb;
  import bsc_pkg::*;

  localparam int LATENCY   = 77;
  localparam int N_PHASES  = 12;
  localparam int PHASE_LEN = 145;
  localparam longint CYCLE_LIMIT = 2000000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  sample_valid = 1'b0;
  logic                  sample_stall;
  sample_t               sample = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  result_t               result;
  logic                  cfg_we = 1'b0;
  logic [2:0]            cfg_index = CFG_AC123;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // shadow copy of the calibration registers
  logic [47:0] cal_ac123, cal_ac456;
  logic [31:0] cal_b12, cal_mcmd;
  logic [1:0]  cal_oss;
  logic [15:0] cal_toff;

  result_t expected_q[$];
  int      n_errors = 0;
  int      n_results = 0;
  longint  cycle_count = 0;

  // directed stimulus row
  typedef struct {
    logic [15:0] raw_t;
    logic [23:0] raw_p;
    bit          typed;
    result_t     want;
  } row_t;

  barometric_sensor_compensation_core dut (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] ashr(input logic [31:0] v, input int s);
    logic signed [31:0] sv;
    sv = $signed(v);
    return 32'(sv >>> s);
  endfunction

  function automatic longint as_int(input logic [31:0] v);
    return longint'($signed(v));
  endfunction

  // datasheet compensation on 32-bit wrapping words
  function automatic result_t compensate(input sample_t s);
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, md, toff, ut, up;
    logic [31:0] x1, x2, x3, b3, b4, b5, b6, b7, p, sq;
    longint mc, d, t, pr, q;
    int oss;
    logic flt;
    result_t r;
    ac1 = sx16(cal_ac123[47:32]); ac2 = sx16(cal_ac123[31:16]);
    ac3 = sx16(cal_ac123[15:0]);
    ac4 = {16'd0, cal_ac456[47:32]}; ac5 = {16'd0, cal_ac456[31:16]};
    ac6 = {16'd0, cal_ac456[15:0]};
    b1 = sx16(cal_b12[31:16]); b2 = sx16(cal_b12[15:0]);
    mc = as_int(sx16(cal_mcmd[31:16])); md = sx16(cal_mcmd[15:0]);
    oss = cal_oss; toff = sx16(cal_toff);
    ut = {16'd0, s.raw_temperature};
    up = {8'd0, s.raw_pressure_bytes} >> (8 - oss);
    flt = 1'b0;

    // temperature
    x1 = ashr((ut - ac6) * ac5, 15);
    d = as_int(x1 + md);
    if (d == 0) begin
      flt = 1'b1;
      x2 = (mc > 0) ? S32_MAX : ((mc < 0) ? S32_MIN : 32'd0);
    end else begin
      q = (mc * 2048) / d;
      x2 = q[31:0];
    end
    b5 = x1 + x2 - toff;
    t = as_int(ashr(b5 + 32'd8, 4));
    if (t > 32767) begin t = 32767; flt = 1'b1; end
    if (t < -32768) begin t = -32768; flt = 1'b1; end

    // pressure
    b6 = b5 - B6_BASE;
    sq = ashr(b6 * b6, 12);
    x1 = ashr(b2 * sq, 11);
    x2 = ashr(ac2 * b6, 11);
    x3 = x1 + x2;
    b3 = ashr(((ac1 * 32'd4 + x3) << oss) + 32'd2, 2);
    x1 = ashr(ac3 * b6, 13);
    x2 = ashr(b1 * sq, 16);
    x3 = ashr(x1 + x2 + 32'd2, 2);
    b4 = (ac4 * (x3 + B4_BIAS)) >> 15;
    b7 = (up - b3) * (B7_SCALE >> oss);
    if (b4 == 0) begin
      flt = 1'b1;
      pr = P_MAX;
    end else begin
      p = (b7 < S32_MIN) ? (b7 * 32'd2) / b4 : (b7 / b4) * 32'd2;
      x1 = ashr(p, 8);
      x1 = x1 * x1;
      x1 = ashr(x1 * P_COEF_SQ, 16);
      x2 = ashr(32'd0 - P_COEF_LIN * p, 16);
      pr = as_int(p + ashr(x1 + x2 + P_BIAS, 4));
      if (pr < 0) begin pr = 0; flt = 1'b1; end
      if (pr > P_MAX) begin pr = P_MAX; flt = 1'b1; end
    end
    r.temperature_tenths = t[15:0];
    r.pressure_pa = pr[17:0];
    r.fault = flt;
    return r;
  endfunction

  // write all six registers, one per cycle, block idle
  task automatic load_calibration(input logic [47:0] a123, input logic [47:0] a456,
                                  input logic [31:0] b12, input logic [31:0] mcmd,
                                  input logic [1:0] oss, input logic [15:0] toff);
    logic [47:0] vals[6];
    vals[CFG_AC123] = a123; vals[CFG_AC456] = a456;
    vals[CFG_B12] = {16'd0, b12}; vals[CFG_MCMD] = {16'd0, mcmd};
    vals[CFG_OSS] = {46'd0, oss}; vals[CFG_TOFF] = {32'd0, toff};
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cal_ac123 = a123; cal_ac456 = a456; cal_b12 = b12; cal_mcmd = mcmd;
    cal_oss = oss; cal_toff = toff;
  endtask

  // offer one beat, with random idle cycles before it when gappy is set
  task automatic send_reading(input sample_t s, input bit typed, input result_t want,
                              input bit gappy);
    while (gappy && $urandom_range(99) < 19) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample <= s;
    do @(posedge clk); while (sample_stall);
    expected_q.push_back(typed ? want : compensate(s));
  endtask

  // quiesce: all results back, then let the pipeline drain
  task automatic drain();
    sample_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
  endtask

  // sender
  initial begin
    row_t    rows[$];
    row_t    rw;
    result_t rst_want;
    sample_t s;
    int      n_sent;
    cal_ac123 = '0; cal_ac456 = '0; cal_b12 = '0; cal_mcmd = '0;
    cal_oss = '0; cal_toff = TOFF_RESET;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // after reset: both divisors zero, temperature (-520 + 8) >> 4
    rst_want.temperature_tenths = -16'sd32;
    rst_want.pressure_pa = P_MAX;
    rst_want.fault = 1'b1;
    rows.push_back('{16'h0000, 24'h000000, 1'b1, rst_want});
    rows.push_back('{16'hFFFF, 24'hFFFFFF, 1'b1, rst_want});
    rows.push_back('{16'h8000, 24'h800000, 1'b1, rst_want});
    rows.push_back('{16'h7FFF, 24'h7FFFFF, 1'b1, rst_want});
    rows.push_back('{16'h5555, 24'hAAAAAA, 1'b1, rst_want});
    rows.push_back('{16'hAAAA, 24'h555555, 1'b1, rst_want});
    foreach (rows[i]) begin
      s.raw_temperature = rows[i].raw_t;
      s.raw_pressure_bytes = rows[i].raw_p;
      send_reading(s, rows[i].typed, rows[i].want, 1'b0);
    end
    drain();

    // datasheet calibration, field extremes and a typical reading
    load_calibration({16'd408, 16'hFFB8, 16'hC7D1}, {16'd32741, 16'd32757, 16'd23153},
                     {16'd6190, 16'd4}, {16'hDDF9, 16'd2868}, 2'd0, 16'd0);
    rows.delete();
    rw.typed = 1'b0; rw.want = '0;
    foreach (rw.raw_t[b]) begin
      rw.raw_t = 16'd27898; rw.raw_p = 24'd23843 << 8;
      rows.push_back(rw);
    end
    rows = rows[0:0];
    rw.raw_t = 16'h0000; rw.raw_p = 24'h000000; rows.push_back(rw);
    rw.raw_t = 16'hFFFF; rw.raw_p = 24'hFFFFFF; rows.push_back(rw);
    rw.raw_t = 16'h0000; rw.raw_p = 24'hFFFFFF; rows.push_back(rw);
    rw.raw_t = 16'hFFFF; rw.raw_p = 24'h000000; rows.push_back(rw);
    rw.raw_t = 16'd23153; rw.raw_p = 24'h5D2300; rows.push_back(rw);
    foreach (rows[i]) begin
      s.raw_temperature = rows[i].raw_t;
      s.raw_pressure_bytes = rows[i].raw_p;
      send_reading(s, 1'b0, rows[i].want, 1'b0);
    end
    drain();

    // random phases; the first few pin down the corner settings
    n_sent = 0;
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        // temperature divisor zero, MC positive, lowest offset
        0: load_calibration(48'd0, {16'd32741, 16'd0, 16'd0}, 32'd0,
                            {16'h7FFF, 16'd0}, 2'd3, 16'h8000);
        // temperature divisor zero, MC negative, highest offset
        1: load_calibration(48'd0, {16'hFFFF, 16'd0, 16'd0}, 32'd0,
                            {16'h8000, 16'd0}, 2'd0, 16'h7FFF);
        2: load_calibration('1, '1, '1, '1, 2'd3, 16'hFFFF);
        3: load_calibration({16'd408, 16'hFFB8, 16'hC7D1}, {16'd32741, 16'd32757, 16'd23153},
                            {16'd6190, 16'd4}, {16'hDDF9, 16'd2868}, 2'd1, 16'd520);
        default: load_calibration(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                                  $urandom, $urandom, 2'($urandom_range(3)),
                                  16'($urandom));
      endcase
      for (int k = 0; k < PHASE_LEN; k++) begin
        s.raw_temperature = 16'($urandom);
        s.raw_pressure_bytes = 24'($urandom);
        // in phase 3, keep most readings near the datasheet operating point
        if (ph == 3 && $urandom_range(3) != 0) begin
          s.raw_temperature = 16'($urandom_range(20000, 36000));
          s.raw_pressure_bytes = 24'($urandom_range(20000, 45000)) << 7;
        end
        // a long stretch with no gaps in the middle of the run
        send_reading(s, 1'b0, '0, !(n_sent >= 600 && n_sent < 900));
        n_sent++;
      end
      drain();
    end

    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // receiver: random stalls, one long hold-off mid-phase, one quiet stretch
  always @(posedge clk) begin
    int  hold;
    bit  held;
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold > 0) begin
      result_stall <= 1'b1;
      hold--;
    end else if (!held && n_results >= 320) begin
      held = 1'b1;
      hold = 400;
      result_stall <= 1'b1;
    end else if (n_results >= 700 && n_results < 1000) begin
      result_stall <= 1'b0;
    end else begin
      result_stall <= ($urandom_range(99) < 19);
    end
  end

  // result checker
  always @(posedge clk) begin
    result_t e;
    if (!rst && result_valid && !result_stall) begin
      n_results++;
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected: %p", result);
        n_errors++;
      end else begin
        e = expected_q.pop_front();
        if (result.temperature_tenths !== e.temperature_tenths) begin
          $error("temperature_tenths expected %0d actual %0d",
                 e.temperature_tenths, result.temperature_tenths);
          n_errors++;
        end
        if (result.pressure_pa !== e.pressure_pa) begin
          $error("pressure_pa expected %0d actual %0d", e.pressure_pa, result.pressure_pa);
          n_errors++;
        end
        if (result.fault !== e.fault) begin
          $error("fault expected %0b actual %0b", e.fault, result.fault);
          n_errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule
